@@ sv/hmm_pkg.sv @@
`timescale 1ns / 1ps

package hmm_pkg;

   localparam int MAX_DIM_DEFAULT = 64;

   // transaction operation codes
   localparam logic [1:0] OP_WRITE_A = 2'd0;
   localparam logic [1:0] OP_WRITE_B = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   // csr register indexes
   localparam logic [1:0] CSR_SIZE_M = 2'd0;
   localparam logic [1:0] CSR_SIZE_N = 2'd1;
   localparam logic [1:0] CSR_SIZE_K = 2'd2;

   localparam logic [6:0]  SIZE_RESET = 7'd64;
   localparam logic [15:0] HALF_QNAN  = 16'h7E00;
   localparam logic [14:0] HALF_INF   = 15'h7C00;

   // leading zero count of a nonzero 27-bit word
   function automatic logic [4:0] lzc27(input logic [26:0] x);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 27; i++) begin
         if (x[i]) begin
            n = 5'(26 - i);
         end
      end
      return n;
   endfunction

endpackage

@@ sv/half_matrix_multiply.sv @@
`timescale 1ns / 1ps
// Channel  | Ports                                               | Direction
// req      | req_valid, req_stall, req_operation, req_row_index, | in
//          | req_col_index, req_element_bits                     |
// rsp      | rsp_valid, rsp_stall, rsp_out_row, rsp_out_col,     | out
//          | rsp_result_bits, rsp_range_error                    |
// csr      | csr_write, csr_index, csr_data                      | in
//
// A compute transaction (k = effective size_k) runs each product through the one shared
// multiply / align / add / round unit in six steps (five when a zero, infinity or NaN skips
// the add), fed by a registered read of each element store. Range errors and k of zero
// go straight to the done step.
// Reset is synchronous; stores are not cleared. req_stall is high while a compute runs;
// a finished result waits in its own step until the rsp register is free.
module half_matrix_multiply #(
   parameter int MAX_DIM = hmm_pkg::MAX_DIM_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [5:0]  req_row_index,
   input  logic [5:0]  req_col_index,
   input  logic [15:0] req_element_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_out_row,
   output logic [5:0]  rsp_out_col,
   output logic [15:0] rsp_result_bits,
   output logic        rsp_range_error,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_DIM + 1);
   localparam int SW    = (CW > 7) ? CW : 7;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FETCH = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_NORM  = 4'd3;
   localparam logic [3:0] S_ALIGN = 4'd4;
   localparam logic [3:0] S_ADD   = 4'd5;
   localparam logic [3:0] S_RND   = 4'd6;
   localparam logic [3:0] S_CONV  = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [15:0] mem_a [DEPTH];
   logic [15:0] mem_b [DEPTH];

   logic [3:0]  state_ff, state_in;
   logic [6:0]  size_m_ff, size_n_ff, size_k_ff;
   logic [CW-1:0] p_ff, p_in, kk_ff, kk_in;
   logic [5:0]  row_ff, row_in, col_ff, col_in;
   logic [AW-1:0] a_addr_ff, a_addr_in, b_addr_ff, b_addr_in;
   logic [15:0] a_rd_ff, b_rd_ff;

   logic [21:0] pm_ff, pm_in;
   logic signed [8:0] pe_ff, pe_in;
   logic        ps_ff, ps_in, pz_ff, pz_in, pi_ff, pi_in, pn_ff, pn_in;
   logic [23:0] om_ff, om_in;
   logic signed [8:0] oe_ff, oe_in;

   logic [23:0] acc_m_ff, acc_m_in;
   logic signed [8:0] acc_e_ff, acc_e_in;
   logic        acc_s_ff, acc_s_in, acc_z_ff, acc_z_in, acc_i_ff, acc_i_in;
   logic        acc_n_ff, acc_n_in;

   logic [26:0] big_ff, big_in, small_ff, small_in;
   logic signed [8:0] al_e_ff, al_e_in;
   logic        al_s_ff, al_s_in, al_sub_ff, al_sub_in;
   logic [27:0] sum_ff, sum_in;
   logic signed [8:0] sum_e_ff, sum_e_in;
   logic        sum_s_ff, sum_s_in;

   logic [15:0] res_bits_ff, res_bits_in;
   logic        res_err_ff, res_err_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [15:0] rsp_bits_ff, rsp_bits_in;
   logic        rsp_err_ff, rsp_err_in;

   logic          we_a, we_b;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_full, a_full, b_full;
   logic [5:0]    addr_row, addr_col;
   logic [CW-1:0] addr_p;
   logic [SW-1:0] eff_m, eff_n, eff_k;
   logic          out_free;

   // operand decode and product
   logic [10:0] ma, mb;
   logic [4:0]  ea, eb;
   logic        za, zb, ia, ib, na, nb;
   logic [4:0]  plz;
   logic        acc_big;
   logic signed [9:0] dlt;
   logic [8:0]  dsh;
   logic [26:0] sx, sshift;
   logic        sticky;
   logic [4:0]  slz;
   logic [26:0] nrm;
   logic signed [8:0] ne;
   logic        rup;
   logic [24:0] mr;
   logic signed [8:0] he, shs;
   logic [4:0]  sh;
   logic [14:0] h15, hr;
   logic [12:0] rem13;
   logic [23:0] q, rem24, halfv;
   logic [CW-1:0] p_nx;

   assign eff_m = (SW'(size_m_ff) > SW'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(size_m_ff);
   assign eff_n = (SW'(size_n_ff) > SW'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(size_n_ff);
   assign eff_k = (SW'(size_k_ff) > SW'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(size_k_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign p_nx     = p_ff + CW'(1);

   assign wr_full  = 32'(req_row_index) * 32'(MAX_DIM) + 32'(req_col_index);
   assign wr_addr  = wr_full[AW-1:0];

   assign addr_row = (state_ff == S_IDLE) ? req_row_index : row_ff;
   assign addr_col = (state_ff == S_IDLE) ? req_col_index : col_ff;
   assign addr_p   = (state_ff == S_IDLE) ? '0 : p_nx;
   assign a_full   = 32'(addr_row) * 32'(MAX_DIM) + 32'(addr_p);
   assign b_full   = 32'(addr_p) * 32'(MAX_DIM) + 32'(addr_col);

   always_comb begin
      state_in    = state_ff;
      p_in        = p_ff;
      kk_in       = kk_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      a_addr_in   = a_addr_ff;
      b_addr_in   = b_addr_ff;
      pm_in       = pm_ff;
      pe_in       = pe_ff;
      ps_in       = ps_ff;
      pz_in       = pz_ff;
      pi_in       = pi_ff;
      pn_in       = pn_ff;
      om_in       = om_ff;
      oe_in       = oe_ff;
      acc_m_in    = acc_m_ff;
      acc_e_in    = acc_e_ff;
      acc_s_in    = acc_s_ff;
      acc_z_in    = acc_z_ff;
      acc_i_in    = acc_i_ff;
      acc_n_in    = acc_n_ff;
      big_in      = big_ff;
      small_in    = small_ff;
      al_e_in     = al_e_ff;
      al_s_in     = al_s_ff;
      al_sub_in   = al_sub_ff;
      sum_in      = sum_ff;
      sum_e_in    = sum_e_ff;
      sum_s_in    = sum_s_ff;
      res_bits_in = res_bits_ff;
      res_err_in  = res_err_ff;
      rsp_row_in  = rsp_row_ff;
      rsp_col_in  = rsp_col_ff;
      rsp_bits_in = rsp_bits_ff;
      rsp_err_in  = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      we_a        = 1'b0;
      we_b        = 1'b0;

      ma  = {a_rd_ff[14:10] != 5'd0, a_rd_ff[9:0]};
      mb  = {b_rd_ff[14:10] != 5'd0, b_rd_ff[9:0]};
      ea  = (a_rd_ff[14:10] == 5'd0) ? 5'd1 : a_rd_ff[14:10];
      eb  = (b_rd_ff[14:10] == 5'd0) ? 5'd1 : b_rd_ff[14:10];
      za  = a_rd_ff[14:0] == 15'd0;
      zb  = b_rd_ff[14:0] == 15'd0;
      ia  = a_rd_ff[14:0] == hmm_pkg::HALF_INF;
      ib  = b_rd_ff[14:0] == hmm_pkg::HALF_INF;
      na  = a_rd_ff[14:10] == 5'd31 && a_rd_ff[9:0] != 10'd0;
      nb  = b_rd_ff[14:10] == 5'd31 && b_rd_ff[9:0] != 10'd0;

      plz = hmm_pkg::lzc27({2'b00, pm_ff, 3'b000});

      acc_big = (acc_e_ff > oe_ff) || (acc_e_ff == oe_ff && acc_m_ff >= om_ff);
      dlt     = acc_big ? (10'(acc_e_ff) - 10'(oe_ff)) : (10'(oe_ff) - 10'(acc_e_ff));
      dsh     = dlt[8:0];
      sx      = acc_big ? {om_ff, 3'b000} : {acc_m_ff, 3'b000};
      if (dsh >= 9'd27) begin
         sshift = '0;
         sticky = 1'b1;
      end else begin
         sshift = sx >> dsh;
         sticky = |(sx & ~({27{1'b1}} << dsh));
      end

      // normalize and round the raw sum
      slz = hmm_pkg::lzc27(sum_ff[26:0]);
      if (sum_ff[27]) begin
         nrm = {sum_ff[27:2], sum_ff[1] | sum_ff[0]};
         ne  = sum_e_ff + 9'sd1;
      end else begin
         nrm = sum_ff[26:0] << slz;
         ne  = sum_e_ff - $signed({4'b0000, slz});
      end
      rup = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
      mr  = {1'b0, nrm[26:3]} + 25'(rup);

      // fp32 accumulator to fp16
      he    = acc_e_ff + 9'sd38;
      h15   = {he[4:0], acc_m_ff[22:13]};
      rem13 = acc_m_ff[12:0];
      shs   = 9'sd14 - he;
      sh    = shs[4:0];
      q     = acc_m_ff >> sh;
      rem24 = acc_m_ff & ~(24'hFFFFFF << sh);
      halfv = 24'd1 << (sh - 5'd1);
      if (he >= 9'sd1) begin
         hr = h15 + 15'(rem13 > 13'h1000 || (rem13 == 13'h1000 && h15[0]));
      end else begin
         hr = q[14:0] + 15'(rem24 > halfv || (rem24 == halfv && q[0]));
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  hmm_pkg::OP_WRITE_A: begin
                     we_a = 32'(req_row_index) < 32'(MAX_DIM)
                         && 32'(req_col_index) < 32'(MAX_DIM);
                  end
                  hmm_pkg::OP_WRITE_B: begin
                     we_b = 32'(req_row_index) < 32'(MAX_DIM)
                         && 32'(req_col_index) < 32'(MAX_DIM);
                  end
                  hmm_pkg::OP_COMPUTE: begin
                     row_in   = req_row_index;
                     col_in   = req_col_index;
                     acc_z_in = 1'b1;
                     acc_i_in = 1'b0;
                     acc_n_in = 1'b0;
                     acc_s_in = 1'b0;
                     if (SW'(req_row_index) >= eff_m || SW'(req_col_index) >= eff_n) begin
                        res_bits_in = '0;
                        res_err_in  = 1'b1;
                        state_in    = S_DONE;
                     end else if (eff_k == '0) begin
                        res_bits_in = '0;
                        res_err_in  = 1'b0;
                        state_in    = S_DONE;
                     end else begin
                        kk_in     = CW'(eff_k);
                        p_in      = '0;
                        a_addr_in = a_full[AW-1:0];
                        b_addr_in = b_full[AW-1:0];
                        state_in  = S_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FETCH: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            pm_in    = ma * mb;
            pe_in    = $signed({4'b0000, ea}) + $signed({4'b0000, eb}) - 9'sd50;
            ps_in    = a_rd_ff[15] ^ b_rd_ff[15];
            pn_in    = na | nb | (ia & zb) | (ib & za);
            pi_in    = (ia | ib) & !pn_in;
            pz_in    = (za | zb) & !pn_in & !pi_in;
            state_in = S_NORM;
         end
         S_NORM: begin
            om_in    = 24'({2'b00, pm_ff} << plz);
            oe_in    = pe_ff - $signed({4'b0000, plz});
            state_in = S_ALIGN;
         end
         S_ALIGN: begin
            state_in = S_ADD;
            if (acc_n_ff || pn_ff || (acc_i_ff && pi_ff && acc_s_ff != ps_ff)) begin
               acc_n_in = 1'b1;
               state_in = S_RND;
            end else if (acc_i_ff || pz_ff) begin
               state_in = S_RND;
            end else if (pi_ff) begin
               acc_i_in = 1'b1;
               acc_s_in = ps_ff;
               state_in = S_RND;
            end else if (acc_z_ff) begin
               acc_z_in = 1'b0;
               acc_m_in = om_ff;
               acc_e_in = oe_ff;
               acc_s_in = ps_ff;
               state_in = S_RND;
            end
            big_in    = acc_big ? {acc_m_ff, 3'b000} : {om_ff, 3'b000};
            small_in  = {sshift[26:1], sshift[0] | sticky};
            al_e_in   = acc_big ? acc_e_ff : oe_ff;
            al_s_in   = acc_big ? acc_s_ff : ps_ff;
            al_sub_in = acc_s_ff != ps_ff;
            // special cases skip the adder: flag it with an empty sum marker
            sum_s_in  = state_in == S_ADD;
         end
         S_ADD: begin
            sum_in   = al_sub_ff ? ({1'b0, big_ff} - {1'b0, small_ff})
                                 : ({1'b0, big_ff} + {1'b0, small_ff});
            sum_e_in = al_e_ff - 9'sd3;
            state_in = S_RND;
         end
         S_RND: begin
            if (sum_s_ff) begin
               if (sum_ff == '0) begin
                  acc_z_in = 1'b1;
                  acc_s_in = 1'b0;
               end else begin
                  acc_s_in = al_s_ff;
                  if (mr[24]) begin
                     acc_m_in = 24'h800000;
                     acc_e_in = ne + 9'sd4;
                  end else begin
                     acc_m_in = mr[23:0];
                     acc_e_in = ne + 9'sd3;
                  end
               end
            end
            p_in = p_nx;
            if (p_nx == kk_ff) begin
               state_in = S_CONV;
            end else begin
               a_addr_in = a_full[AW-1:0];
               b_addr_in = b_full[AW-1:0];
               state_in  = S_FETCH;
            end
         end
         S_CONV: begin
            res_err_in = 1'b0;
            if (acc_n_ff) begin
               res_bits_in = hmm_pkg::HALF_QNAN;
            end else if (acc_i_ff || (!acc_z_ff && he >= 9'sd31)) begin
               res_bits_in = {acc_s_ff, hmm_pkg::HALF_INF};
            end else if (acc_z_ff) begin
               res_bits_in = '0;
            end else if (he < -9'sd10) begin
               res_bits_in = {acc_s_ff, 15'd0};
            end else begin
               res_bits_in = {acc_s_ff, hr};
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_col_in   = col_ff;
               rsp_bits_in  = res_bits_ff;
               rsp_err_in   = res_err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[wr_addr] <= req_element_bits;
      end
      a_rd_ff <= mem_a[a_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         mem_b[wr_addr] <= req_element_bits;
      end
      b_rd_ff <= mem_b[b_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         size_m_ff    <= hmm_pkg::SIZE_RESET;
         size_n_ff    <= hmm_pkg::SIZE_RESET;
         size_k_ff    <= hmm_pkg::SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               hmm_pkg::CSR_SIZE_M: size_m_ff <= csr_data;
               hmm_pkg::CSR_SIZE_N: size_n_ff <= csr_data;
               hmm_pkg::CSR_SIZE_K: size_k_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      kk_ff       <= kk_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      a_addr_ff   <= a_addr_in;
      b_addr_ff   <= b_addr_in;
      pm_ff       <= pm_in;
      pe_ff       <= pe_in;
      ps_ff       <= ps_in;
      pz_ff       <= pz_in;
      pi_ff       <= pi_in;
      pn_ff       <= pn_in;
      om_ff       <= om_in;
      oe_ff       <= oe_in;
      acc_m_ff    <= acc_m_in;
      acc_e_ff    <= acc_e_in;
      acc_s_ff    <= acc_s_in;
      acc_z_ff    <= acc_z_in;
      acc_i_ff    <= acc_i_in;
      acc_n_ff    <= acc_n_in;
      big_ff      <= big_in;
      small_ff    <= small_in;
      al_e_ff     <= al_e_in;
      al_s_ff     <= al_s_in;
      al_sub_ff   <= al_sub_in;
      sum_ff      <= sum_in;
      sum_e_ff    <= sum_e_in;
      sum_s_ff    <= sum_s_in;
      res_bits_ff <= res_bits_in;
      res_err_ff  <= res_err_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign req_stall       = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_result_bits = rsp_bits_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

@@ sv/hmm_checker.sv @@
`timescale 1ns / 1ps

module hmm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [5:0]  rsp_out_row,
   input logic [5:0]  rsp_out_col,
   input logic [15:0] rsp_result_bits,
   input logic        rsp_range_error
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_bits)
         && $stable(rsp_out_row) && $stable(rsp_out_col))
      else $error("rsp transaction changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_result_bits == 16'd0)
      else $error("range error with nonzero result");

   // a compute keeps the block busy in the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_operation == hmm_pkg::OP_COMPUTE |=> req_stall)
      else $error("compute transaction did not occupy the block");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind half_matrix_multiply hmm_checker u_hmm_checker (.*);
